### sv/cti_pkg.sv
// Shared types and constants of the cylinder triangle index generator.
package cti_pkg;

	localparam int IDX_W       = 17;
	localparam int REG_W       = 9;
	localparam int WIDE_W      = 18;
	localparam int DIV_STAGES  = 4;
	localparam int DIV_BITS    = 2;
	localparam int QUO_W       = DIV_STAGES * DIV_BITS;
	localparam int CFG_IDX_W   = 1;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 56;

	localparam logic [REG_W-1:0] MIN_SLICES = REG_W'(3);
	localparam logic [REG_W-1:0] MAX_SLICES = REG_W'(256);
	localparam logic [REG_W-1:0] MIN_RINGS  = REG_W'(2);
	localparam logic [REG_W-1:0] MAX_RINGS  = REG_W'(256);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SLICE_COUNT = 1'b0,
		REG_RING_COUNT  = 1'b1
	} reg_index_t;

	typedef enum logic [1:0] {
		REGION_TOP    = 2'd0,
		REGION_SIDE   = 2'd1,
		REGION_BOTTOM = 2'd2
	} region_t;

	typedef struct packed {
		logic [REG_W-1:0] slices;
		logic [REG_W-1:0] rings;
	} cfg_t;

	// rem holds the side-band offset and later the remainder of the division by 2S;
	// slice holds the face number on the top cap and the slice on the bottom cap.
	typedef struct packed {
		logic [IDX_W-1:0] rem;
		logic [QUO_W-1:0] quo;
		logic [IDX_W-1:0] vtot;
		logic [REG_W-1:0] slice;
		region_t          region;
		logic             oor;
	} item_t;

	typedef struct packed {
		logic             oor;
		region_t          region;
		logic [IDX_W-1:0] c;
		logic [IDX_W-1:0] b;
		logic [IDX_W-1:0] a;
	} result_t;

endpackage

### sv/cti_cfg.sv
// Configuration registers with saturation to the supported slice and ring range.
module cti_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [cti_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cti_pkg::REG_W-1:0]      cfg_data,
	output cti_pkg::cfg_t                  cfg
);
	import cti_pkg::*;

	logic [REG_W-1:0] slices_q;
	logic [REG_W-1:0] rings_q;

	function automatic logic [REG_W-1:0] clamp(input logic [REG_W-1:0] v,
		input logic [REG_W-1:0] lo, input logic [REG_W-1:0] hi);
		logic [REG_W-1:0] r;
		r = v;
		if (r < lo) r = lo;
		if (r > hi) r = hi;
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slices_q <= MIN_SLICES;
			rings_q  <= MIN_RINGS;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_SLICE_COUNT: slices_q <= clamp(cfg_data, MIN_SLICES, MAX_SLICES);
				REG_RING_COUNT:  rings_q  <= clamp(cfg_data, MIN_RINGS, MAX_RINGS);
			endcase
		end
	end

	assign cfg.slices = slices_q;
	assign cfg.rings  = rings_q;

endmodule

### sv/cti_classify.sv
// First two pipeline stages: mesh size products and region decode of the face number.
module cti_classify (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cti_pkg::cfg_t              cfg,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [cti_pkg::IDX_W-1:0]  face,
	output logic                       out_valid,
	input  logic                       out_ready,
	output cti_pkg::item_t             out_item
);
	import cti_pkg::*;

	logic             vld_s1;
	logic [IDX_W-1:0] face_s1;
	logic [IDX_W-1:0] sk_s1;
	logic             vld_s2;
	item_t            item_s2;
	logic             rdy_s1;
	logic             rdy_s2;

	logic [IDX_W-1:0]  sk_c;
	logic [WIDE_W-1:0] s_w;
	logic [WIDE_W-1:0] f_w;
	logic [WIDE_W-1:0] total_w;
	logic [WIDE_W-1:0] side_end_w;
	logic [WIDE_W-1:0] vtot_w;
	item_t             item_c;

	assign rdy_s2   = !vld_s2 || out_ready;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	assign sk_c = IDX_W'(cfg.slices) * IDX_W'(cfg.rings);

	always_comb begin
		s_w        = WIDE_W'(cfg.slices);
		f_w        = WIDE_W'(face_s1);
		total_w    = WIDE_W'(sk_s1) << 1;
		// The side bands end at S + 2S(K-1), which is 2SK - S.
		side_end_w = total_w - s_w;
		vtot_w     = (s_w << 1) + WIDE_W'(sk_s1) + WIDE_W'(cfg.rings);

		item_c        = '0;
		item_c.vtot   = IDX_W'(vtot_w);
		item_c.rem    = IDX_W'(f_w - s_w);
		item_c.oor    = f_w >= total_w;
		item_c.region = REGION_TOP;
		if (!item_c.oor) begin
			if (f_w < s_w) begin
				item_c.region = REGION_TOP;
				item_c.slice  = REG_W'(face_s1);
			end else if (f_w < side_end_w) begin
				item_c.region = REGION_SIDE;
			end else begin
				item_c.region = REGION_BOTTOM;
				item_c.slice  = REG_W'(f_w - side_end_w);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= in_valid;
			if (rdy_s2) vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			face_s1 <= face;
			sk_s1   <= sk_c;
		end
		if (rdy_s2 && vld_s1) item_s2 <= item_c;
	end

	assign out_valid = vld_s2;
	assign out_item  = item_s2;

endmodule

### sv/cti_divider.sv
// Pipelined restoring divider: splits the side-band offset into band and remainder mod 2S.
module cti_divider (
	input  logic            clk,
	input  logic            arst_n,
	input  cti_pkg::cfg_t   cfg,
	input  logic            in_valid,
	output logic            in_ready,
	input  cti_pkg::item_t  in_item,
	output logic            out_valid,
	input  logic            out_ready,
	output cti_pkg::item_t  out_item
);
	import cti_pkg::*;

	logic              div_vld_s  [DIV_STAGES];
	item_t             div_item_s [DIV_STAGES];
	logic              rdy        [DIV_STAGES];
	item_t             nxt        [DIV_STAGES];
	logic [REG_W:0]    divisor;

	assign divisor = {cfg.slices, 1'b0};

	for (genvar st = 0; st < DIV_STAGES; st++) begin : g_stage
		item_t             src;
		logic              src_vld;
		logic              dst_rdy;
		logic [WIDE_W-1:0] rem_w;
		logic [WIDE_W-1:0] trial;

		if (st == 0) begin : g_first
			assign src     = in_item;
			assign src_vld = in_valid;
		end else begin : g_next
			assign src     = div_item_s[st-1];
			assign src_vld = div_vld_s[st-1];
		end

		if (st == DIV_STAGES - 1) begin : g_last
			assign dst_rdy = out_ready;
		end else begin : g_mid
			assign dst_rdy = rdy[st+1];
		end

		assign rdy[st] = !div_vld_s[st] || dst_rdy;

		// Two quotient bits per stage, most significant first.
		always_comb begin
			nxt[st] = src;
			rem_w   = WIDE_W'(src.rem);
			trial   = '0;
			for (int b = 0; b < DIV_BITS; b++) begin
				trial = WIDE_W'(divisor) << (QUO_W - 1 - st * DIV_BITS - b);
				if (rem_w >= trial) begin
					rem_w = rem_w - trial;
					nxt[st].quo = nxt[st].quo |
						(QUO_W'(1) << (QUO_W - 1 - st * DIV_BITS - b));
				end
			end
			nxt[st].rem = IDX_W'(rem_w);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_vld_s[st] <= 1'b0;
			end else if (rdy[st]) begin
				div_vld_s[st] <= src_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[st] && src_vld) div_item_s[st] <= nxt[st];
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = div_vld_s[DIV_STAGES-1];
	assign out_item  = div_item_s[DIV_STAGES-1];

endmodule

### sv/cti_assemble.sv
// Last two pipeline stages: band row offset, then the three vertex indices per region.
module cti_assemble (
	input  logic              clk,
	input  logic              arst_n,
	input  cti_pkg::cfg_t     cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  cti_pkg::item_t    in_item,
	output logic              out_valid,
	input  logic              out_ready,
	output cti_pkg::result_t  out_res
);
	import cti_pkg::*;

	logic              vld_s7;
	item_t             item_s7;
	logic [IDX_W-1:0]  prod_s7;
	logic              vld_s8;
	result_t           res_s8;
	logic              rdy_s7;
	logic              rdy_s8;

	logic [IDX_W-1:0]  prod_c;
	logic [WIDE_W-1:0] s_w;
	logic [WIDE_W-1:0] sl_w;
	logic [WIDE_W-1:0] upper_w;
	logic [WIDE_W-1:0] lower_w;
	logic [WIDE_W-1:0] vtot_w;
	result_t           res_c;

	assign rdy_s8   = !vld_s8 || out_ready;
	assign rdy_s7   = !vld_s7 || rdy_s8;
	assign in_ready = rdy_s7;

	assign prod_c = IDX_W'(in_item.quo) * (IDX_W'(cfg.slices) + IDX_W'(1));

	always_comb begin
		s_w     = WIDE_W'(cfg.slices);
		sl_w    = WIDE_W'(item_s7.slice);
		vtot_w  = WIDE_W'(item_s7.vtot);
		// On the side the slice is half the remainder, its low bit picks the triangle of the quad.
		upper_w = WIDE_W'(prod_s7) + s_w + WIDE_W'(item_s7.rem[IDX_W-1:1]);
		lower_w = upper_w + s_w + WIDE_W'(1);

		res_c        = '0;
		res_c.oor    = item_s7.oor;
		res_c.region = item_s7.region;
		if (item_s7.oor) begin
			res_c.region = REGION_TOP;
		end else begin
			unique case (item_s7.region)
				REGION_TOP: begin
					res_c.a = IDX_W'(sl_w);
					res_c.b = IDX_W'(sl_w + s_w);
					res_c.c = IDX_W'(sl_w + s_w + WIDE_W'(1));
				end
				REGION_SIDE: begin
					if (!item_s7.rem[0]) begin
						res_c.a = IDX_W'(upper_w);
						res_c.b = IDX_W'(lower_w);
						res_c.c = IDX_W'(upper_w + WIDE_W'(1));
					end else begin
						res_c.a = IDX_W'(upper_w + WIDE_W'(1));
						res_c.b = IDX_W'(lower_w);
						res_c.c = IDX_W'(lower_w + WIDE_W'(1));
					end
				end
				REGION_BOTTOM: begin
					res_c.a = IDX_W'(vtot_w - s_w + sl_w);
					res_c.b = IDX_W'(vtot_w - (s_w << 1) + sl_w);
					res_c.c = IDX_W'(vtot_w - (s_w << 1) + sl_w - WIDE_W'(1));
				end
				default: begin
					res_c = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else begin
			if (rdy_s7) vld_s7 <= in_valid;
			if (rdy_s8) vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s7 && in_valid) begin
			item_s7 <= in_item;
			prod_s7 <= prod_c;
		end
		if (rdy_s8 && vld_s7) res_s8 <= res_c;
	end

	assign out_valid = vld_s8;
	assign out_res   = res_s8;

endmodule

### sv/cylinder_triangle_index_generator.sv
// Capped-cylinder triangle index generator: one triangle number in, three vertex indices out.
// It takes one face number per clock unless stalled and returns its three vertex indices,
// region and out-of-range flag: two stages compute 2SK, the vertex total and the region, four
// stages run a restoring division by 2S at two quotient bits each to find the band and the
// quad within it, one stage multiplies the band by S+1, and the last stage forms the indices
// into the output register. Every stage holds its own valid bit, so a stall on the output
// side fills empty stages before the input side is held. Slice and ring counts must be written
// through the configuration port only while no beat is in flight; the block does not check it.
module cylinder_triangle_index_generator (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [cti_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [cti_pkg::REG_W-1:0]        cfg_data,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// Fields from bit 0: face_number[16:0], zero fill.
	input  logic [cti_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// Fields from bit 0: vertex_first[16:0], vertex_second[33:17], vertex_third[50:34],
	// region[52:51], out_of_range[53], zero fill.
	output logic [cti_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
	import cti_pkg::*;

	cfg_t    cfg;
	logic    cls_valid;
	logic    cls_ready;
	item_t   cls_item;
	logic    div_valid;
	logic    div_ready;
	item_t   div_item;
	result_t res;

	cti_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	cti_classify u_classify (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.face      (s_axis_tdata[IDX_W-1:0]),
		.out_valid (cls_valid),
		.out_ready (cls_ready),
		.out_item  (cls_item)
	);

	cti_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (cls_valid),
		.in_ready  (cls_ready),
		.in_item   (cls_item),
		.out_valid (div_valid),
		.out_ready (div_ready),
		.out_item  (div_item)
	);

	cti_assemble u_assemble (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (div_valid),
		.in_ready  (div_ready),
		.in_item   (div_item),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res)
	);

	assign m_axis_tdata = OUT_TDATA_W'(res);

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res.oor |->
			(res.a == '0) && (res.b == '0) && (res.c == '0) && (res.region == REGION_TOP))
		else $error("out-of-range beat carries non-zero indices");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !res.oor && (res.region == REGION_TOP) |->
			res.b == res.a + IDX_W'(cfg.slices))
		else $error("top cap fan does not reach the first ring");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !res.oor && (res.region == REGION_BOTTOM) |->
			res.a == res.c + IDX_W'(cfg.slices) + IDX_W'(1))
		else $error("bottom cap fan does not start from the last ring");
`endif

endmodule

### sim/tb_top.sv
// Self-checking testbench for the cylinder triangle index generator.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import cti_pkg::*;

	localparam int PIPE_LATENCY = 8;
	localparam int HOLD_CYCLES  = 300;
	localparam int PHASE_ITEMS  = 70;
	localparam int FACE_MAX     = (1 << IDX_W) - 1;

	typedef struct {
		logic [IDX_W-1:0] first;
		logic [IDX_W-1:0] second;
		logic [IDX_W-1:0] third;
		logic [1:0]       region;
		logic             oor;
	} triangle_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [REG_W-1:0]       cfg_data;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	triangle_t   pending_triangles[$];
	int unsigned cur_slices;
	int unsigned cur_rings;
	int          mismatch_count;
	bit          sender_steady;
	bit          receiver_steady;
	bit          hold_req;

	cylinder_triangle_index_generator dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("FAIL");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 40);
	endfunction

	function automatic int unsigned clamp_count(logic [REG_W-1:0] v, int unsigned lo,
			int unsigned hi);
		int unsigned c;
		c = v;
		if (c < lo) c = lo;
		if (c > hi) c = hi;
		return c;
	endfunction

	function automatic int unsigned face_total();
		return 2 * cur_slices * cur_rings;
	endfunction

	function automatic triangle_t predict_triangle(logic [IDX_W-1:0] face);
		int unsigned s, k, f, band_tris, total, g, band, r, sl, upper, lower, vtot, last_ring;
		int unsigned a, b, c;
		triangle_t t;
		s = cur_slices;
		k = cur_rings;
		f = face;
		band_tris = 2 * s * (k - 1);
		total = 2 * s * k;
		a = 0;
		b = 0;
		c = 0;
		t.region = REGION_TOP;
		t.oor = 1'b0;
		if (f >= total) begin
			t.oor = 1'b1;
		end else if (f < s) begin
			a = f;
			b = f + s;
			c = f + s + 1;
		end else if (f < s + band_tris) begin
			g = f - s;
			band = g / (2 * s);
			r = g % (2 * s);
			sl = r >> 1;
			upper = band * (s + 1) + s + sl;
			lower = upper + s + 1;
			// Even triangles of a quad take the upper edge, odd ones the lower edge.
			if (r[0] == 1'b0) begin
				a = upper;
				b = lower;
				c = upper + 1;
			end else begin
				a = upper + 1;
				b = lower;
				c = lower + 1;
			end
			t.region = REGION_SIDE;
		end else begin
			sl = f - s - band_tris;
			vtot = 2 * s + (s + 1) * k;
			last_ring = vtot - s - (s + 1);
			a = vtot - s + sl;
			b = last_ring + sl + 1;
			c = last_ring + sl;
			t.region = REGION_BOTTOM;
		end
		t.first = a[IDX_W-1:0];
		t.second = b[IDX_W-1:0];
		t.third = c[IDX_W-1:0];
		return t;
	endfunction

	// Random face number biased towards the region boundaries and beyond the last triangle.
	function automatic logic [IDX_W-1:0] random_face();
		int unsigned total, side_end, r;
		total = face_total();
		side_end = cur_slices + 2 * cur_slices * (cur_rings - 1);
		r = $urandom_range(0, 99);
		if (r < 70)
			return IDX_W'($urandom_range(0, total - 1));
		if (r < 80) begin
			case ($urandom_range(0, 5))
				0: return IDX_W'(0);
				1: return IDX_W'(cur_slices - 1);
				2: return IDX_W'(cur_slices);
				3: return IDX_W'(side_end - 1);
				4: return IDX_W'(side_end);
				default: return IDX_W'(total - 1);
			endcase
		end
		if (r < 90 && total <= FACE_MAX)
			return IDX_W'($urandom_range(total, FACE_MAX));
		return IDX_W'($urandom_range(0, FACE_MAX));
	endfunction

	task automatic send_face(logic [IDX_W-1:0] face);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= IN_TDATA_W'(face);
		do
			@(posedge clk);
		while (!s_axis_tready);
		pending_triangles.push_back(predict_triangle(face));
		gap = sender_steady ? 0 : pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_for_drain();
		s_axis_tvalid <= 1'b0;
		while (pending_triangles.size() != 0)
			@(posedge clk);
		repeat (PIPE_LATENCY) @(posedge clk);
	endtask

	task automatic write_count(reg_index_t idx, logic [REG_W-1:0] value);
		wait_for_drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_SLICE_COUNT)
			cur_slices = clamp_count(value, MIN_SLICES, MAX_SLICES);
		else
			cur_rings = clamp_count(value, MIN_RINGS, MAX_RINGS);
	endtask

	// Reset geometry: three slices and two rings, twelve triangles.
	task automatic test_reset_geometry();
		send_face(0);
		send_face(2);
		send_face(3);
		send_face(4);
		send_face(8);
		send_face(9);
		send_face(11);
		send_face(12);
		send_face(IDX_W'(FACE_MAX));
	endtask

	task automatic test_count_saturation();
		write_count(REG_SLICE_COUNT, 0);
		write_count(REG_RING_COUNT, 1);
		send_face(11);
		send_face(12);
		write_count(REG_SLICE_COUNT, 9'd511);
		write_count(REG_RING_COUNT, 9'd511);
		send_face(0);
		send_face(255);
		send_face(256);
		send_face(257);
		send_face(IDX_W'(130815));
		send_face(IDX_W'(130816));
		send_face(IDX_W'(FACE_MAX));
		write_count(REG_SLICE_COUNT, 9'd257);
		write_count(REG_RING_COUNT, 9'd2);
		send_face(IDX_W'(1023));
		send_face(IDX_W'(1024));
	endtask

	task automatic test_random_geometries();
		logic [REG_W-1:0] s_val, k_val;
		for (int phase = 0; phase < 9; phase++) begin
			if (phase == 0) begin
				s_val = 9'd256;
				k_val = 9'd256;
			end else if (phase == 1) begin
				s_val = 9'd3;
				k_val = 9'd2;
			end else begin
				s_val = ($urandom_range(0, 9) < 3) ? REG_W'($urandom_range(0, 511))
					: REG_W'($urandom_range(3, 64));
				k_val = ($urandom_range(0, 9) < 3) ? REG_W'($urandom_range(0, 511))
					: REG_W'($urandom_range(2, 64));
			end
			write_count(REG_SLICE_COUNT, s_val);
			write_count(REG_RING_COUNT, k_val);
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_face(random_face());
		end
	endtask

	task automatic test_back_to_back();
		sender_steady = 1'b1;
		receiver_steady = 1'b1;
		for (int i = 0; i < 60; i++)
			send_face(random_face());
		receiver_steady = 1'b0;
		sender_steady = 1'b0;
	endtask

	// The receiver holds off long enough for the pipeline to fill and stall the input side.
	task automatic test_output_stall();
		sender_steady = 1'b1;
		hold_req = 1'b1;
		for (int i = 0; i < 40; i++)
			send_face(random_face());
		sender_steady = 1'b0;
	endtask

	initial begin : ready_driver
		int  count;
		bit  level;
		count = 0;
		level = 1'b0;
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
				level = 1'b1;
				count = 0;
				m_axis_tready <= 1'b1;
			end else if (receiver_steady) begin
				m_axis_tready <= 1'b1;
			end else begin
				if (count != 0) begin
					count--;
				end else if (level) begin
					count = pick_gap();
					if (count != 0) begin
						level = 1'b0;
						count--;
					end
				end else begin
					level = 1'b1;
					count = $urandom_range(0, 20);
				end
				m_axis_tready <= level;
			end
		end
	end

	always @(posedge clk) begin
		triangle_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_triangles.size() == 0) begin
				$error("unexpected result beat, tdata %h", m_axis_tdata);
				mismatch_count++;
			end else begin
				want = pending_triangles.pop_front();
				if (m_axis_tdata[16:0] !== want.first) begin
					$error("vertex_first expected %0d actual %0d", want.first,
						m_axis_tdata[16:0]);
					mismatch_count++;
				end
				if (m_axis_tdata[33:17] !== want.second) begin
					$error("vertex_second expected %0d actual %0d", want.second,
						m_axis_tdata[33:17]);
					mismatch_count++;
				end
				if (m_axis_tdata[50:34] !== want.third) begin
					$error("vertex_third expected %0d actual %0d", want.third,
						m_axis_tdata[50:34]);
					mismatch_count++;
				end
				if (m_axis_tdata[52:51] !== want.region) begin
					$error("region expected %0d actual %0d", want.region,
						m_axis_tdata[52:51]);
					mismatch_count++;
				end
				if (m_axis_tdata[53] !== want.oor) begin
					$error("out_of_range expected %0d actual %0d", want.oor,
						m_axis_tdata[53]);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_SLICE_COUNT;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		mismatch_count = 0;
		sender_steady = 1'b0;
		receiver_steady = 1'b0;
		hold_req = 1'b0;
		cur_slices = MIN_SLICES;
		cur_rings = MIN_RINGS;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_geometry();
		test_count_saturation();
		test_random_geometries();
		test_back_to_back();
		test_output_stall();

		wait_for_drain();
		repeat (2 * PIPE_LATENCY) @(posedge clk);
		if (pending_triangles.size() != 0) begin
			$error("%0d results never arrived", pending_triangles.size());
			mismatch_count++;
		end
		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
